// ===== sv/wdf_pkg.sv =====
package wdf_pkg;

    // frame parser phases
    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    localparam logic [6:0] LEN16_CODE     = 7'd126;
    localparam logic [6:0] LEN64_CODE     = 7'd127;
    localparam logic [3:0] EXT16_BYTES    = 4'd2;
    localparam logic [3:0] EXT64_BYTES    = 4'd8;
    localparam logic [3:0] MASK_KEY_BYTES = 4'd4;

    // one result request
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [3:0]  opcode;
        logic        fin;
        logic        last;
        logic        empty;
        logic [63:0] length;
    } result_t;

endpackage

// ===== sv/websocket_frame_deframer.sv =====
// websocket frame deframer: takes a stream of back-to-back websocket frames,
// one byte per request, decodes each header (fin, opcode, 7/16/64-bit length,
// optional mask key) and emits one request per payload byte, unmasked, tagged
// with the frame's opcode, fin, length and a last-of-frame mark. a zero-length
// frame yields one marker request with empty_frame set. rsv bits are ignored
// and there are no protocol error checks. throughput is one byte per cycle
// while stream_ready is high; each byte is decoded by the header/xor logic in
// the cycle it is accepted and its result is registered for the sink. a skid stage
// behind the output register lets the input keep flowing while a result waits,
// so stream_ready only drops when both the output register and the skid stage
// hold results that the sink has not taken.
module websocket_frame_deframer
    import wdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        stream_valid,
    output logic        stream_ready,
    input  logic [7:0]  stream_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  payload_byte,
    output logic [3:0]  frame_opcode_out,
    output logic        final_fragment,
    output logic        frame_last,
    output logic        empty_frame,
    output logic [63:0] payload_length
);

    // parser state
    phase_t      phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic        masked_reg, masked_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        fin_reg, fin_next;
    logic [63:0] left_reg, left_next;
    logic [1:0]  lane_reg, lane_next;

    // output register and skid stage
    logic        out_valid_reg, skid_valid_reg;
    result_t     out_reg, skid_reg;

    logic        step;
    logic        res_valid;
    result_t     res;
    logic [6:0]  len7;
    logic [63:0] len_shift;
    logic [7:0]  key_byte;
    logic        pop;

    assign stream_ready = !skid_valid_reg;
    assign step         = stream_valid && stream_ready;
    assign pop          = out_valid_reg && result_ready;

    assign len7      = stream_byte[6:0];
    assign len_shift = {len_reg[55:0], stream_byte};

    // mask key byte for this payload index, first key byte on lane zero
    always_comb
    begin
        unique case (lane_reg)
            2'd0: key_byte = key_reg[31:24];
            2'd1: key_byte = key_reg[23:16];
            2'd2: key_byte = key_reg[15:8];
            2'd3: key_byte = key_reg[7:0];
        endcase
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HDR0:
                phase_next = PH_HDR1;
            PH_HDR1:
            begin
                if (len7 == LEN16_CODE || len7 == LEN64_CODE)
                    phase_next = PH_EXTLEN;
                else if (stream_byte[7])
                    phase_next = PH_MASK;
                else if (len7 == 7'd0)
                    phase_next = PH_HDR0;
                else
                    phase_next = PH_PAYLOAD;
            end
            PH_EXTLEN:
            begin
                if (count_reg == 4'd1)
                begin
                    if (masked_reg)
                        phase_next = PH_MASK;
                    else if (len_shift == 64'd0)
                        phase_next = PH_HDR0;
                    else
                        phase_next = PH_PAYLOAD;
                end
            end
            PH_MASK:
            begin
                if (count_reg == 4'd1)
                    phase_next = (len_reg == 64'd0) ? PH_HDR0 : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                if (left_reg == 64'd1)
                    phase_next = PH_HDR0;
            end
            default:
                phase_next = PH_HDR1;
        endcase
    end

    // datapath and result
    always_comb
    begin
        count_next  = count_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        masked_next = masked_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        left_next   = left_reg;
        lane_next   = lane_reg;
        res_valid   = 1'b0;
        res         = '0;
        unique case (phase_reg)
            PH_HDR1:
            begin
                masked_next = stream_byte[7];
                if (len7 == LEN16_CODE)
                begin
                    len_next   = 64'd0;
                    count_next = EXT16_BYTES;
                end
                else if (len7 == LEN64_CODE)
                begin
                    len_next   = 64'd0;
                    count_next = EXT64_BYTES;
                end
                else
                begin
                    len_next = {57'd0, len7};
                    if (stream_byte[7])
                    begin
                        key_next   = 32'd0;
                        count_next = MASK_KEY_BYTES;
                    end
                    else if (len7 == 7'd0)
                        res_valid = 1'b1;
                    else
                    begin
                        left_next = {57'd0, len7};
                        lane_next = 2'd0;
                    end
                end
            end
            PH_EXTLEN:
            begin
                len_next   = len_shift;
                count_next = count_reg - 4'd1;
                if (count_reg == 4'd1)
                begin
                    if (masked_reg)
                    begin
                        key_next   = 32'd0;
                        count_next = MASK_KEY_BYTES;
                    end
                    else if (len_shift == 64'd0)
                        res_valid = 1'b1;
                    else
                    begin
                        left_next = len_shift;
                        lane_next = 2'd0;
                    end
                end
            end
            PH_MASK:
            begin
                key_next   = {key_reg[23:0], stream_byte};
                count_next = count_reg - 4'd1;
                if (count_reg == 4'd1)
                begin
                    if (len_reg == 64'd0)
                        res_valid = 1'b1;
                    else
                    begin
                        left_next = len_reg;
                        lane_next = 2'd0;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                left_next        = left_reg - 64'd1;
                lane_next        = lane_reg + 2'd1;
                res_valid        = 1'b1;
                res.payload_byte = stream_byte ^ (masked_reg ? key_byte : 8'd0);
                res.last         = (left_reg == 64'd1);
            end
            default:
            begin
                fin_next    = stream_byte[7];
                opcode_next = stream_byte[3:0];
            end
        endcase
        // zero-length marker
        if (res_valid && phase_reg != PH_PAYLOAD)
        begin
            res.last  = 1'b1;
            res.empty = 1'b1;
        end
        res.opcode = opcode_reg;
        res.fin    = fin_reg;
        res.length = len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            count_reg  <= 4'd0;
            len_reg    <= 64'd0;
            key_reg    <= 32'd0;
            masked_reg <= 1'b0;
            opcode_reg <= 4'd0;
            fin_reg    <= 1'b0;
            left_reg   <= 64'd0;
            lane_reg   <= 2'd0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            masked_reg <= masked_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            left_reg   <= left_next;
            lane_reg   <= lane_next;
        end
    end

    // output register with skid stage; the skid only fills while the output waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (step && res_valid)
        begin
            if (out_valid_reg && !result_ready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (step && res_valid)
        begin
            if (out_valid_reg && !result_ready)
                skid_reg <= res;
            else
                out_reg <= res;
        end
    end

    assign result_valid     = out_valid_reg;
    assign payload_byte     = out_reg.payload_byte;
    assign frame_opcode_out = out_reg.opcode;
    assign final_fragment   = out_reg.fin;
    assign frame_last       = out_reg.last;
    assign empty_frame      = out_reg.empty;
    assign payload_length   = out_reg.length;

endmodule

// ===== sv/wdf_checker.sv =====
module wdf_checker
    import wdf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        stream_valid,
    input logic        stream_ready,
    input logic [7:0]  stream_byte,
    input logic        result_valid,
    input logic        result_ready,
    input logic [7:0]  payload_byte,
    input logic [3:0]  frame_opcode_out,
    input logic        final_fragment,
    input logic        frame_last,
    input logic        empty_frame,
    input logic [63:0] payload_length
);

    // a waiting stream request holds
    assert property (@(posedge clk) disable iff (!rst_n)
        stream_valid && !stream_ready |=> stream_valid && $stable(stream_byte))
    else $error("waiting stream request changed");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(payload_byte)
            && $stable(frame_opcode_out) && $stable(final_fragment)
            && $stable(frame_last) && $stable(empty_frame) && $stable(payload_length))
    else $error("stalled result changed");

    // empty marker is the last and only request of a zero-length frame
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && empty_frame |-> frame_last && payload_byte == 8'd0
            && payload_length == 64'd0)
    else $error("bad empty frame marker");

    // a payload request belongs to a frame of nonzero length
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !empty_frame |-> payload_length != 64'd0)
    else $error("payload request with zero length");

    // a request that is not the last cannot be an empty marker
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !frame_last |-> !empty_frame)
    else $error("empty marker not last");

endmodule

bind websocket_frame_deframer wdf_checker u_wdf_checker (.*);
